### hw/rtl/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg
// Shared constants, codes and types for the sequential list block.
// ----------------------------------------------------------------------------
package slid_pkg;

    localparam int SLID_CAPACITY = 1024;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 11;
    localparam int LEN_W  = 11;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // what an accepted item needs after the accept cycle
    typedef enum logic [1:0] {
        KIND_DONE,
        KIND_INS,
        KIND_DEL,
        KIND_READ
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_READ
    } state_t;

    typedef struct packed {
        logic start;
        logic step_up;
        logic step_dn;
        logic fin_ins;
        logic fin_del;
        logic fin_read;
    } ctl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  run_zero;
        logic  pend;
        logic  out_free;
    } dp_stat_t;

endpackage

### hw/rtl/slid_req_if.sv
// ----------------------------------------------------------------------------
// slid_req_if
// Command channel: valid/ready with one list command per item.
// ----------------------------------------------------------------------------
interface slid_req_if
    import slid_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         count;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output command, output position, output count,
                    output value, input ready);
    modport sink   (input valid, input command, input position, input count,
                    input value, output ready);
endinterface

### hw/rtl/slid_rsp_if.sv
// ----------------------------------------------------------------------------
// slid_rsp_if
// Result channel: valid/ready with status, length and read data per item.
// ----------------------------------------------------------------------------
interface slid_rsp_if
    import slid_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         length;
    logic signed [DATA_W-1:0] read_data;

    modport source (output valid, output status, output length, output read_data,
                    input ready);
    modport sink   (input valid, input status, input length, input read_data,
                    output ready);
endinterface

### hw/rtl/slid_ram.sv
// ----------------------------------------------------------------------------
// slid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hw/rtl/slid_ctrl.sv
// ----------------------------------------------------------------------------
// slid_ctrl
// Sequencer: takes an item, runs the shift or read phase if it needs one, then retires it.
// ----------------------------------------------------------------------------
module slid_ctrl
    import slid_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t ctl
);
    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && stat.out_free)
                begin
                    case (stat.kind)
                        KIND_INS:  state_next = S_INS;
                        KIND_DEL:  state_next = S_DEL;
                        KIND_READ: state_next = S_READ;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_INS, S_DEL:
            begin
                if (stat.run_zero && !stat.pend)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready    = (state_reg == S_IDLE) && stat.out_free;
        ctl          = '0;
        ctl.start    = req_ready && req_valid;
        ctl.step_up  = (state_reg == S_INS) && !stat.run_zero;
        ctl.step_dn  = (state_reg == S_DEL) && !stat.run_zero;
        ctl.fin_ins  = (state_reg == S_INS) && stat.run_zero && !stat.pend;
        ctl.fin_del  = (state_reg == S_DEL) && stat.run_zero && !stat.pend;
        ctl.fin_read = (state_reg == S_READ);
    end

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req_ready)
        else $error("item taken while busy");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_IDLE))
        else $error("read phase overran");

    a_read_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start && stat.kind == KIND_READ) |=> (state_reg == S_READ))
        else $error("read item not sequenced");
endmodule

### hw/rtl/slid_dp.sv
// ----------------------------------------------------------------------------
// slid_dp
// Datapath: command decode, length register, entry store, shift pointers
// and the result register.
// ----------------------------------------------------------------------------
module slid_dp
    import slid_pkg::*;
#(
    parameter int CAPACITY = SLID_CAPACITY
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [CMD_W-1:0]         command,
    input  logic [POS_W-1:0]         position,
    input  logic [POS_W-1:0]         count,
    input  logic signed [DATA_W-1:0] value,
    input  ctl_cmd_t                 ctl,
    output dp_stat_t                 stat,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [STAT_W-1:0]        out_status,
    output logic [LEN_W-1:0]         out_length,
    output logic signed [DATA_W-1:0] out_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    logic [LW-1:0]     len_reg, len_next;
    logic [LW-1:0]     new_len_reg, new_len_next;
    logic [LW-1:0]     run_reg, run_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [AW-1:0]     wr_idx_reg, wr_idx_next;
    logic [AW-1:0]     shift_reg, shift_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              pend_reg, pend_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;

    // decode
    logic [CW-1:0]     posx, cntx, lenx, capx, room, cclamp;
    kind_t             d_kind;
    logic [STAT_W-1:0] d_status;
    logic [CW-1:0]     d_len;
    logic              d_we;
    logic [CW-1:0]     d_rd_start;
    logic [CW-1:0]     d_run;
    logic [CW-1:0]     d_shift;
    logic [CW-1:0]     new_len_x;

    // ram
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    always_comb
    begin
        posx       = CW'(position);
        cntx       = CW'(count);
        lenx       = CW'(len_reg);
        capx       = CW'(CAPACITY);
        room       = lenx - posx + CW'(1);
        cclamp     = (cntx > room) ? room : cntx;
        d_kind     = KIND_DONE;
        d_status   = ST_OK;
        d_len      = lenx;
        d_we       = 1'b0;
        d_rd_start = '0;
        d_run      = '0;
        d_shift    = '0;
        case (command)
            CMD_CLEAR:
            begin
                d_len = '0;
            end
            CMD_APPEND:
            begin
                if (lenx >= capx)
                begin
                    d_status = ST_FULL;
                end
                else
                begin
                    d_we  = 1'b1;
                    d_len = lenx + CW'(1);
                end
            end
            CMD_INSERT:
            begin
                if (posx == '0 || posx > lenx + CW'(1))
                begin
                    d_status = ST_RANGE;
                end
                else if (lenx >= capx)
                begin
                    d_status = ST_FULL;
                end
                else if (posx == lenx + CW'(1))
                begin
                    d_we  = 1'b1;
                    d_len = lenx + CW'(1);
                end
                else
                begin
                    d_kind     = KIND_INS;
                    d_len      = lenx + CW'(1);
                    d_rd_start = lenx - CW'(1);
                    d_run      = room;
                end
            end
            CMD_DELETE:
            begin
                if (posx == '0 || posx > lenx)
                begin
                    d_status = ST_RANGE;
                end
                else
                begin
                    d_len = lenx - cclamp;
                    if (room != cclamp)
                    begin
                        d_kind     = KIND_DEL;
                        d_rd_start = posx - CW'(1) + cclamp;
                        d_run      = room - cclamp;
                        d_shift    = cclamp;
                    end
                end
            end
            CMD_READ:
            begin
                if (posx == '0 || posx > lenx)
                begin
                    d_status = ST_RANGE;
                end
                else
                begin
                    d_kind = KIND_READ;
                end
            end
            default:
            begin
                d_len = lenx;
            end
        endcase
    end

    always_comb
    begin
        stat.kind     = d_kind;
        stat.run_zero = (run_reg == '0);
        stat.pend     = pend_reg;
        stat.out_free = !out_valid_reg || out_ready;
    end

    // entry store ports
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = rd_idx_reg;
        if (ctl.start && d_kind == KIND_READ)
        begin
            ram_re    = 1'b1;
            ram_raddr = AW'(posx - CW'(1));
        end
        else if (ctl.step_up || ctl.step_dn)
        begin
            ram_re = 1'b1;
        end

        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg;
        ram_wdata = ram_rdata;
        if (ctl.start && d_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(lenx);
            ram_wdata = value;
        end
        else if (pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (ctl.fin_ins)
        begin
            ram_we    = 1'b1;
            ram_waddr = base_reg;
            ram_wdata = val_reg;
        end
    end

    slid_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        new_len_x       = CW'(new_len_reg);
        len_next        = len_reg;
        new_len_next    = new_len_reg;
        run_next        = run_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        shift_next      = shift_reg;
        base_next       = base_reg;
        val_next        = val_reg;
        pend_next       = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_data_next   = out_data_reg;

        if (ctl.start)
        begin
            new_len_next = LW'(d_len);
            run_next     = LW'(d_run);
            rd_idx_next  = AW'(d_rd_start);
            shift_next   = AW'(d_shift);
            base_next    = AW'(posx - CW'(1));
            val_next     = value;
            if (d_kind == KIND_DONE)
            begin
                len_next        = LW'(d_len);
                out_valid_next  = 1'b1;
                out_status_next = d_status;
                out_len_next    = d_len[LEN_W-1:0];
                out_data_next   = '0;
            end
        end

        if (ctl.step_up)
        begin
            wr_idx_next = rd_idx_reg + AW'(1);
            rd_idx_next = rd_idx_reg - AW'(1);
            run_next    = run_reg - LW'(1);
            pend_next   = 1'b1;
        end
        else if (ctl.step_dn)
        begin
            wr_idx_next = rd_idx_reg - shift_reg;
            rd_idx_next = rd_idx_reg + AW'(1);
            run_next    = run_reg - LW'(1);
            pend_next   = 1'b1;
        end

        if (ctl.fin_ins || ctl.fin_del)
        begin
            len_next        = new_len_reg;
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_len_next    = new_len_x[LEN_W-1:0];
            out_data_next   = '0;
        end
        else if (ctl.fin_read)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_len_next    = lenx[LEN_W-1:0];
            out_data_next   = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            run_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            run_reg       <= run_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_len_reg    <= new_len_next;
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        shift_reg      <= shift_next;
        base_reg       <= base_next;
        val_reg        <= val_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_length = out_len_reg;
    assign out_data   = out_data_reg;

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(len_reg) <= CW'(CAPACITY))
        else $error("length above capacity");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fin_ins |-> !pend_reg && !ctl.start)
        else $error("write port conflict");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_data_reg == '0))
        else $error("failed item carries read data");
endmodule

### hw/rtl/sequential_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sequential_list_insert_delete
// Ordered list of signed 32-bit words with clear, append, insert, delete-run
// and read commands.
//
// req carries one command per item (command, position, count, value); rsp
// returns one result per item (status, length, read_data). Both are
// valid/ready channels.
// Items are handled one at a time. Clear, append, insert at the tail and any
// rejected command finish in the accept cycle, with the result valid on the
// next cycle. A read fetches its entry in the accept cycle and returns it
// from the read phase. Insert before an existing entry and a delete (clamped
// count) shift the later entries, but a delete finishes in the accept cycle
// when the run reaches the end of the list. The entries move one per cycle
// through the single write port of the entry RAM.
// The result sits in an output register; a new item is taken while it waits
// only if rsp is taken in the same cycle, so a stalled receiver holds req off.
// Reset empties the list; the entry RAM itself is not cleared.
// ----------------------------------------------------------------------------
module sequential_list_insert_delete
    import slid_pkg::*;
#(
    parameter int CAPACITY = SLID_CAPACITY
) (
    input logic        clk,
    input logic        rst_n,
    slid_req_if.sink   req,
    slid_rsp_if.source rsp
);
    ctl_cmd_t ctl;
    dp_stat_t stat;

    slid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    slid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (req.command),
        .position   (req.position),
        .count      (req.count),
        .value      (req.value),
        .ctl        (ctl),
        .stat       (stat),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_status (rsp.status),
        .out_length (rsp.length),
        .out_data   (rsp.read_data)
    );
endmodule
